// ===== rtl/pid_pkg.sv =====
// shared widths, register indexes, reset values and stage payload types for the pid step core
package pid_pkg;

	// sample and accumulator widths
	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 32;
	localparam int REG_W    = 16;
	localparam int FRAC_W   = 8;

	// derived datapath widths
	localparam int ERR_W  = SAMPLE_W + 1;
	localparam int DIFF_W = ERR_W + 1;
	localparam int ACC_W  = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
	localparam int P_W    = REG_W + ERR_W;
	localparam int I_W    = REG_W + SUM_W;
	localparam int D_W    = REG_W + DIFF_W;
	localparam int PD_MAX = (P_W > D_W) ? P_W : D_W;
	localparam int RAW_W  = ((PD_MAX > I_W) ? PD_MAX : I_W) + 2;
	localparam int SHR_W  = RAW_W - FRAC_W;

	// stream and config port widths
	localparam int IN_DATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((REG_W + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_DT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD_DT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd4;

	// register reset values
	localparam logic [REG_W-1:0] KP_RESET      = 16'h0100;
	localparam logic [REG_W-1:0] KI_DT_RESET   = 16'h0000;
	localparam logic [REG_W-1:0] KD_DT_RESET   = 16'h0000;
	localparam logic [REG_W-1:0] OUT_MIN_RESET = 16'h8000;
	localparam logic [REG_W-1:0] OUT_MAX_RESET = 16'h7fff;

	// integrator saturation limits, sign extended to the accumulator width
	localparam logic signed [ACC_W-1:0] SUM_HI_EXT =
		{{(ACC_W - SUM_W + 1){1'b0}}, {(SUM_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SUM_LO_EXT =
		{{(ACC_W - SUM_W + 1){1'b1}}, {(SUM_W - 1){1'b0}}};
	localparam logic [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W - 1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W - 1){1'b0}}};

	typedef struct packed {
		logic [REG_W-1:0] kp;
		logic [REG_W-1:0] ki_dt;
		logic [REG_W-1:0] kd_dt;
	} gains_t;

	typedef struct packed {
		logic [REG_W-1:0] out_min;
		logic [REG_W-1:0] out_max;
	} limits_t;

	typedef struct packed {
		logic [ERR_W-1:0]  err;
		logic [DIFF_W-1:0] diff;
		logic [SUM_W-1:0]  sum;
	} err_stage_t;

	typedef struct packed {
		logic [P_W-1:0] p_term;
		logic [I_W-1:0] i_term;
		logic [D_W-1:0] d_term;
	} prod_stage_t;

endpackage

// ===== rtl/pid_err.sv =====
// input register, error forming, derivative difference and saturating integrator
module pid_err (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pid_pkg::SAMPLE_W-1:0] setpoint,
	input  logic [pid_pkg::SAMPLE_W-1:0] measurement,
	output logic                         out_valid,
	input  logic                         out_ready,
	output pid_pkg::err_stage_t          out_stage
);

	localparam int SAMPLE_W = pid_pkg::SAMPLE_W;
	localparam int ERR_W    = pid_pkg::ERR_W;
	localparam int DIFF_W   = pid_pkg::DIFF_W;
	localparam int SUM_W    = pid_pkg::SUM_W;
	localparam int ACC_W    = pid_pkg::ACC_W;

	logic                v_s1;
	logic [SAMPLE_W-1:0] sp_s1;
	logic [SAMPLE_W-1:0] ms_s1;
	logic                v_s2;
	pid_pkg::err_stage_t stage_s2;
	logic [ERR_W-1:0]    prev_err_q;
	logic [SUM_W-1:0]    err_sum_q;

	logic                ready_s2;
	logic                adv;
	logic signed [ERR_W-1:0]  err_c;
	logic signed [DIFF_W-1:0] diff_c;
	logic signed [ACC_W-1:0]  acc_c;
	logic [SUM_W-1:0]         sum_c;

	// handshake chain
	assign ready_s2 = !v_s2 || out_ready;
	assign in_ready = !v_s1 || ready_s2;
	assign adv      = v_s1 && ready_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sp_s1 <= setpoint;
			ms_s1 <= measurement;
		end
	end

	// error, difference and widened integrator sum
	always_comb begin
		err_c  = {sp_s1[SAMPLE_W-1], sp_s1} - {ms_s1[SAMPLE_W-1], ms_s1};
		diff_c = {err_c[ERR_W-1], err_c} - {prev_err_q[ERR_W-1], prev_err_q};
		acc_c  = {{(ACC_W - SUM_W){err_sum_q[SUM_W-1]}}, err_sum_q}
			+ {{(ACC_W - ERR_W){err_c[ERR_W-1]}}, err_c};
		if (acc_c > pid_pkg::SUM_HI_EXT) begin
			sum_c = pid_pkg::SUM_HI;
		end else if (acc_c < pid_pkg::SUM_LO_EXT) begin
			sum_c = pid_pkg::SUM_LO;
		end else begin
			sum_c = acc_c[SUM_W-1:0];
		end
	end

	// controller state, updated once per request in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			err_sum_q  <= '0;
		end else if (adv) begin
			prev_err_q <= err_c;
			err_sum_q  <= sum_c;
		end
	end

	// error stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stage_s2.err  <= err_c;
			stage_s2.diff <= diff_c;
			stage_s2.sum  <= sum_c;
		end
	end

	assign out_valid = v_s2;
	assign out_stage = stage_s2;

endmodule

// ===== rtl/pid_mul.sv =====
// the three gain products, registered
module pid_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pid_pkg::gains_t      gains,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pid_pkg::err_stage_t  in_stage,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pid_pkg::prod_stage_t out_stage
);

	localparam int P_W = pid_pkg::P_W;
	localparam int I_W = pid_pkg::I_W;
	localparam int D_W = pid_pkg::D_W;

	logic                  v_s3;
	pid_pkg::prod_stage_t  prod_s3;
	logic signed [P_W-1:0] p_c;
	logic signed [I_W-1:0] i_c;
	logic signed [D_W-1:0] d_c;

	assign in_ready = !v_s3 || out_ready;

	// signed multiplies, operands extend to the product width
	assign p_c = $signed(gains.kp)    * $signed(in_stage.err);
	assign i_c = $signed(gains.ki_dt) * $signed(in_stage.sum);
	assign d_c = $signed(gains.kd_dt) * $signed(in_stage.diff);

	// product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s3.p_term <= p_c;
			prod_s3.i_term <= i_c;
			prod_s3.d_term <= d_c;
		end
	end

	assign out_valid = v_s3;
	assign out_stage = prod_s3;

endmodule

// ===== rtl/pid_out.sv =====
// product sum with floor shift to q8.8, then clamp into the output register
module pid_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pid_pkg::limits_t          limits,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  pid_pkg::prod_stage_t      in_stage,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [pid_pkg::REG_W-1:0] drive,
	output logic                      was_clamped
);

	localparam int P_W    = pid_pkg::P_W;
	localparam int I_W    = pid_pkg::I_W;
	localparam int D_W    = pid_pkg::D_W;
	localparam int RAW_W  = pid_pkg::RAW_W;
	localparam int SHR_W  = pid_pkg::SHR_W;
	localparam int REG_W  = pid_pkg::REG_W;
	localparam int FRAC_W = pid_pkg::FRAC_W;

	logic                    v_s4;
	logic [SHR_W-1:0]        raw_s4;
	logic                    v_q;
	logic [REG_W-1:0]        drive_q;
	logic                    clamp_q;
	logic                    ready_s4;
	logic signed [RAW_W-1:0] raw_c;
	logic signed [SHR_W-1:0] shr_v;
	logic signed [SHR_W-1:0] lo_ext;
	logic signed [SHR_W-1:0] hi_ext;
	logic [REG_W-1:0]        drive_c;
	logic                    clamp_c;

	assign ready_s4 = !v_q || out_ready;
	assign in_ready = !v_s4 || ready_s4;

	// exact sum of the three terms; dropping the low bits floors the shift
	assign raw_c = {{(RAW_W - P_W){in_stage.p_term[P_W-1]}}, in_stage.p_term}
		+ {{(RAW_W - I_W){in_stage.i_term[I_W-1]}}, in_stage.i_term}
		+ {{(RAW_W - D_W){in_stage.d_term[D_W-1]}}, in_stage.d_term};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (in_ready) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s4 <= raw_c[RAW_W-1:FRAC_W];
		end
	end

	// clamp, lower limit tested first
	always_comb begin
		shr_v  = raw_s4;
		lo_ext = {{(SHR_W - REG_W){limits.out_min[REG_W-1]}}, limits.out_min};
		hi_ext = {{(SHR_W - REG_W){limits.out_max[REG_W-1]}}, limits.out_max};
		if (shr_v < lo_ext) begin
			drive_c = limits.out_min;
			clamp_c = 1'b1;
		end else if (shr_v > hi_ext) begin
			drive_c = limits.out_max;
			clamp_c = 1'b1;
		end else begin
			drive_c = raw_s4[REG_W-1:0];
			clamp_c = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ready_s4) begin
			v_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && ready_s4) begin
			drive_q <= drive_c;
			clamp_q <= clamp_c;
		end
	end

	assign out_valid   = v_q;
	assign drive       = drive_q;
	assign was_clamped = clamp_q;

endmodule

// ===== rtl/pid_controller_step_core.sv =====
// top level of the fixed point pid step core: config registers, stage wiring, checks
//
// Each request on the s_axis channel carries one setpoint and one measurement
// (signed q8.8). The core forms the error, updates the previous error and a
// saturating 32-bit error sum, and returns one result on m_axis: the drive
// value kp*e + ki_dt*sum + kd_dt*(e - previous e), floored back to q8.8 and
// clamped to [out_min, out_max], with tuser set when the clamp acted.
// Gains and limits are written through the cfg channel (always ready); the
// user must write them only while no request is in flight (the core does
// not check). Indexes above four are ignored. From acceptance to m_axis_tvalid
// a request passes the input register, error and integrator stage, multiplier
// stage, sum stage and clamp register. The integrator loop closes in the error
// stage, so back to back samples run at full rate: one request is accepted
// every cycle while results are taken. On a receiver stall each stage holds its
// result, empty stages keep filling and s_axis_tready drops only when every stage
// is occupied. Reset clears the pipeline, both state registers and restores kp to
// 1.0, the other gains to zero and the limits to the full 16-bit range.
module pid_controller_step_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// config write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pid_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [pid_pkg::REG_W-1:0]              cfg_data,
	// request stream
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [pid_pkg::IN_DATA_W-1:0]          s_axis_tdata,  // setpoint, measurement
	// result stream
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [pid_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // drive
	output logic                                   m_axis_tuser   // was_clamped
);

	localparam int SAMPLE_W = pid_pkg::SAMPLE_W;
	localparam int REG_W    = pid_pkg::REG_W;

	logic [REG_W-1:0] kp_q;
	logic [REG_W-1:0] ki_dt_q;
	logic [REG_W-1:0] kd_dt_q;
	logic [REG_W-1:0] out_min_q;
	logic [REG_W-1:0] out_max_q;

	pid_pkg::gains_t      gains;
	pid_pkg::limits_t     limits;
	pid_pkg::err_stage_t  err_stage;
	pid_pkg::prod_stage_t prod_stage;
	logic                 err_valid;
	logic                 err_ready;
	logic                 prod_valid;
	logic                 prod_ready;
	logic [REG_W-1:0]     drive;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q      <= pid_pkg::KP_RESET;
			ki_dt_q   <= pid_pkg::KI_DT_RESET;
			kd_dt_q   <= pid_pkg::KD_DT_RESET;
			out_min_q <= pid_pkg::OUT_MIN_RESET;
			out_max_q <= pid_pkg::OUT_MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pid_pkg::REG_KP:      kp_q      <= cfg_data;
				pid_pkg::REG_KI_DT:   ki_dt_q   <= cfg_data;
				pid_pkg::REG_KD_DT:   kd_dt_q   <= cfg_data;
				pid_pkg::REG_OUT_MIN: out_min_q <= cfg_data;
				pid_pkg::REG_OUT_MAX: out_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign gains.kp       = kp_q;
	assign gains.ki_dt    = ki_dt_q;
	assign gains.kd_dt    = kd_dt_q;
	assign limits.out_min = out_min_q;
	assign limits.out_max = out_max_q;

	// error and integrator stage
	pid_err u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.setpoint    (s_axis_tdata[SAMPLE_W-1:0]),
		.measurement (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.out_valid   (err_valid),
		.out_ready   (err_ready),
		.out_stage   (err_stage)
	);

	// gain products
	pid_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains),
		.in_valid  (err_valid),
		.in_ready  (err_ready),
		.in_stage  (err_stage),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_stage (prod_stage)
	);

	// sum, shift and clamp
	pid_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.limits      (limits),
		.in_valid    (prod_valid),
		.in_ready    (prod_ready),
		.in_stage    (prod_stage),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.drive       (drive),
		.was_clamped (m_axis_tuser)
	);

	assign m_axis_tdata = pid_pkg::OUT_DATA_W'(drive);

	// an empty output register means every stage can move
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while the output register is empty");

	// a clamped result sits exactly on one of the limits
	a_clamp_on_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (drive == out_min_q || drive == out_max_q))
		else $error("clamped drive is not on a limit");

	// an unclamped result lies within ordered limits
	a_unclamped_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser && ($signed(out_min_q) <= $signed(out_max_q)))
		|-> ($signed(drive) >= $signed(out_min_q) && $signed(drive) <= $signed(out_max_q)))
		else $error("unclamped drive outside the limits");

	// the product stage only empties toward the sum stage when that one can take it
	a_mul_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(prod_valid && !prod_ready) |=> prod_valid)
		else $error("product stage lost a stalled result");

endmodule

// ===== tb/sv/pid_controller_step_core_test.sv =====
// self-checking stream testbench for the pid step core
`timescale 1ns / 100ps

module pid_controller_step_core_test;

	localparam int SAMPLE_W   = pid_pkg::SAMPLE_W;
	localparam int SUM_W      = pid_pkg::SUM_W;
	localparam int REG_W      = pid_pkg::REG_W;
	localparam int FRAC_W     = pid_pkg::FRAC_W;
	localparam int CFG_IDX_W  = pid_pkg::CFG_IDX_W;
	localparam int IN_DATA_W  = pid_pkg::IN_DATA_W;
	localparam int OUT_DATA_W = pid_pkg::OUT_DATA_W;

	// request acceptance to result valid
	localparam int LATENCY     = 4;
	localparam int CYCLE_LIMIT = 800000;
	localparam int PHASE_ITEMS = 130;
	localparam int RAND_PHASES = 6;
	localparam int LONG_HOLD   = 80;
	localparam int WINDUP_RUN  = 25;
	localparam int MAX_REPORTS = 10;

	// indexes past the last register, which the core must ignore
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = pid_pkg::REG_OUT_MAX + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] measurement;
		logic signed [SAMPLE_W-1:0] setpoint;
	} sample_t;

	typedef struct packed {
		logic signed [REG_W-1:0] drive;
		logic                    clamped;
	} drive_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [REG_W-1:0]      cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	// controller copy: registers and state
	logic signed [REG_W-1:0] gain_p   = pid_pkg::KP_RESET;
	logic signed [REG_W-1:0] gain_i   = pid_pkg::KI_DT_RESET;
	logic signed [REG_W-1:0] gain_d   = pid_pkg::KD_DT_RESET;
	logic signed [REG_W-1:0] limit_lo = pid_pkg::OUT_MIN_RESET;
	logic signed [REG_W-1:0] limit_hi = pid_pkg::OUT_MAX_RESET;
	longint                  err_prev  = 0;
	longint                  err_total = 0;

	sample_t pending_samples[$];
	drive_t  expected_drives[$];
	sample_t current_sample;

	int  send_gap       = 0;
	int  recv_gap       = 0;
	int  hold_left      = 0;
	int  mismatch_count = 0;
	int  cycle_count    = 0;
	logic no_idle         = 1'b0;
	logic long_hold_go    = 1'b0;
	logic long_hold_taken = 1'b0;

	pid_controller_step_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// one control step: error, saturating sum, pid sum floored to q8.8, clamp
	task automatic advance_controller(input sample_t smp, output drive_t res);
		longint err, diff, total, raw, top, bottom;
		top    = (longint'(1) << (SUM_W - 1)) - 1;
		bottom = -top - 1;
		err    = longint'(smp.setpoint) - longint'(smp.measurement);
		diff   = err - err_prev;
		total  = err_total + err;
		if (total > top)
			total = top;
		else if (total < bottom)
			total = bottom;
		err_total = total;
		err_prev  = err;
		raw = (longint'(gain_p) * err + longint'(gain_i) * total + longint'(gain_d) * diff)
			>>> FRAC_W;
		// lower limit wins when the limits are crossed
		if (raw < longint'(limit_lo)) begin
			res.drive   = limit_lo;
			res.clamped = 1'b1;
		end else if (raw > longint'(limit_hi)) begin
			res.drive   = limit_hi;
			res.clamped = 1'b1;
		end else begin
			res.drive   = raw[REG_W-1:0];
			res.clamped = 1'b0;
		end
	endtask

	// register write request, mirrored into the controller copy on acceptance
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pid_pkg::REG_KP:      gain_p   = val;
			pid_pkg::REG_KI_DT:   gain_i   = val;
			pid_pkg::REG_KD_DT:   gain_d   = val;
			pid_pkg::REG_OUT_MIN: limit_lo = val;
			pid_pkg::REG_OUT_MAX: limit_hi = val;
			default:     ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [REG_W-1:0] kp, input logic [REG_W-1:0] ki,
			input logic [REG_W-1:0] kd, input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
		write_reg(pid_pkg::REG_KP, kp);
		write_reg(pid_pkg::REG_KI_DT, ki);
		write_reg(pid_pkg::REG_KD_DT, kd);
		write_reg(pid_pkg::REG_OUT_MIN, lo);
		write_reg(pid_pkg::REG_OUT_MAX, hi);
	endtask

	// block until every queued request went in and every result came back
	task automatic wait_drained();
		while (pending_samples.size() != 0 || s_axis_tvalid || expected_drives.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_sample(input logic [SAMPLE_W-1:0] sp, input logic [SAMPLE_W-1:0] ms);
		sample_t smp;
		smp.setpoint    = sp;
		smp.measurement = ms;
		pending_samples.push_back(smp);
	endtask

	function automatic logic [REG_W-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return '0;
			3:       return 16'h0100;
			4:       return REG_W'($urandom_range(0, 1023)) - 16'd512;
			default: return REG_W'($urandom());
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_extreme();
		case ($urandom_range(0, 3))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return '0;
			default: return '1;
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t smp;
		case ($urandom_range(0, 3))
			0: smp = $urandom();
			1: begin
				// tracking close to the target
				smp.setpoint    = $urandom();
				smp.measurement = smp.setpoint + SAMPLE_W'($urandom_range(0, 512)) - 16'd256;
			end
			2: begin
				smp.setpoint    = pick_extreme();
				smp.measurement = pick_extreme();
			end
			default: begin
				smp.setpoint    = SAMPLE_W'($urandom_range(0, 2047)) - 16'd1024;
				smp.measurement = SAMPLE_W'($urandom_range(0, 2047)) - 16'd1024;
			end
		endcase
		return smp;
	endfunction

	// request driver: predicts on acceptance, then offers the next queued sample
	always @(posedge clk) begin
		drive_t res;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				advance_controller(current_sample, res);
				expected_drives.push_back(res);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != 0) begin
					send_gap      <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_samples.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (!no_idle && $urandom_range(0, 15) == 0) begin
					send_gap      <= $urandom_range(0, 10);
					s_axis_tvalid <= 1'b0;
				end else begin
					current_sample = pending_samples.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {current_sample.measurement, current_sample.setpoint};
				end
			end
		end
	end

	// long receiver hold-off, counted here so the sender keeps pushing
	always @(posedge clk) begin
		if (long_hold_go && !long_hold_taken) begin
			long_hold_taken <= 1'b1;
			hold_left       <= LONG_HOLD;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor: compare against the oldest prediction, then pick next ready
	always @(posedge clk) begin
		drive_t exp_res;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap      <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_drives.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected result: drive %0d clamped %0b",
							$signed(m_axis_tdata[REG_W-1:0]), m_axis_tuser);
				end else begin
					exp_res = expected_drives.pop_front();
					if (m_axis_tdata[REG_W-1:0] !== exp_res.drive
							|| m_axis_tuser !== exp_res.clamped) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("drive mismatch: expected %0d clamped %0b, got %0d clamped %0b",
								exp_res.drive, exp_res.clamped,
								$signed(m_axis_tdata[REG_W-1:0]), m_axis_tuser);
					end
				end
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap      <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 15) == 0) begin
				recv_gap      <= $urandom_range(0, 10);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// test sequence
	initial begin
		logic [REG_W-1:0] lim_a, lim_b;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: full-scale errors, bit patterns, unit steps
		@(negedge clk);
		queue_sample('0, '0);
		queue_sample(S_MAX, S_MIN);
		queue_sample(S_MIN, S_MAX);
		queue_sample(S_MAX, S_MAX);
		queue_sample(S_MIN, S_MIN);
		queue_sample(16'h0001, '0);
		queue_sample('0, 16'h0001);
		queue_sample(16'h5555, 16'haaaa);
		queue_sample(16'haaaa, 16'h5555);
		wait_drained();

		// extreme gains, narrow limits; writes to spare indexes change nothing
		write_all(S_MIN, S_MAX, S_MAX, 16'hfc18, 16'h03e8);
		for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
			write_reg(i[CFG_IDX_W-1:0], REG_W'($urandom()));
		@(negedge clk);
		queue_sample(S_MAX, S_MIN);
		queue_sample(S_MIN, S_MAX);
		queue_sample('0, '0);
		queue_sample(16'd100, -16'sd100);
		queue_sample('1, '0);
		wait_drained();

		// crossed limits: low limit above high limit
		write_all(16'h0100, '0, '0, 16'h0100, 16'hff00);
		@(negedge clk);
		queue_sample(-16'sd512, '0);
		queue_sample('0, '0);
		queue_sample(16'd1024, '0);
		queue_sample(16'd200, '0);
		wait_drained();

		// integrator run up, down and back under full-scale error, seen through a unit ki
		write_all('0, 16'h0001, '0, S_MIN, S_MAX);
		no_idle <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < WINDUP_RUN; i++)
			queue_sample(S_MAX, S_MIN);
		for (int i = 0; i < 2 * WINDUP_RUN; i++)
			queue_sample(S_MIN, S_MAX);
		for (int i = 0; i < WINDUP_RUN; i++)
			queue_sample(S_MAX, S_MIN);
		wait_drained();
		no_idle <= 1'b0;

		// random settings and samples
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			lim_a = $urandom();
			lim_b = $urandom();
			case ($urandom_range(0, 4))
				0: write_all(pick_gain(), pick_gain(), pick_gain(), S_MIN, S_MAX);
				1: begin
					if ($signed(lim_a) > $signed(lim_b))
						write_all(pick_gain(), pick_gain(), pick_gain(), lim_b, lim_a);
					else
						write_all(pick_gain(), pick_gain(), pick_gain(), lim_a, lim_b);
				end
				2: write_all(pick_gain(), pick_gain(), pick_gain(), lim_a, lim_b);
				3: write_all(pick_gain(), pick_gain(), pick_gain(), lim_a, lim_a);
				default: write_all(pick_gain(), pick_gain(), pick_gain(), S_MAX, S_MIN);
			endcase
			@(negedge clk);
			if (ph == RAND_PHASES - 1)
				no_idle <= 1'b1;
			if (ph == 2)
				long_hold_go <= 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				pending_samples.push_back(random_sample());
			wait_drained();
		end

		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0 && expected_drives.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pid_pkg.sv
rtl/pid_err.sv
rtl/pid_mul.sv
rtl/pid_out.sv
rtl/pid_controller_step_core.sv
tb/sv/pid_controller_step_core_test.sv
